/* rtl/dtce_pkg.sv */
// Package for the decision tree classifier with weighted error counting.
// Holds the geometry constants, the opcodes, the transaction layouts and the
// command and status types shared by the controller and the datapath.
package dtce_pkg;

  localparam int NODES     = 256;
  localparam int FEATURES  = 64;
  localparam int MAX_DEPTH = 16;

  localparam int NODE_AW = $clog2(NODES);
  localparam int FEAT_AW = $clog2(FEATURES);
  localparam int STEP_W  = $clog2(MAX_DEPTH + 1);

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    OP_WRITE_NODE = 2'd0,
    OP_WRITE_FEAT = 2'd1,
    OP_CLASSIFY   = 2'd2,
    OP_CLEAR      = 2'd3
  } opcode_t;

  // Input tdata, last member in the lowest bits
  typedef struct packed {
    logic [23:0]        example_weight;
    logic               true_label;
    logic [23:0]        neg_wt;
    logic [23:0]        pos_wt;
    logic [7:0]         child_gt;
    logic [7:0]         child_le;
    logic [5:0]         feat_sel;
    logic               is_leaf;
    logic signed [15:0] value;
    logic [7:0]         address;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic        walk_fault;
    logic [31:0] weighted_error;
    logic        mismatch;
    logic        predicted_negative;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] thresh;
    logic               leaf;
    logic [5:0]         feat;
    logic [7:0]         left;
    logic [7:0]         right;
  } node_t;

  typedef struct packed {
    logic [23:0] pos;
    logic [23:0] neg;
  } weights_t;

  typedef struct packed {
    logic take;
    logic feat_rd;
    logic step;
    logic grade;
    logic finish;
    logic fault;
  } dp_cmd_t;

  typedef struct packed {
    logic classify;
    logic leaf;
    logic out_hold;
  } dp_sts_t;

endpackage

/* rtl/dtce_ctrl.sv */
// Controller for the decision tree classifier: input handshake and walk
// sequencing state machine with the depth counter.
// Depends on dtce_pkg.
module dtce_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  dtce_pkg::dp_sts_t sts,
  output dtce_pkg::dp_cmd_t cmd
);
  import dtce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_NODE = 4'b0010,
    S_FEAT = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              fault_r, fault_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    fault_nxt = fault_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = !sts.out_hold;
        cmd.take  = in_tvalid && !sts.out_hold;
        if (cmd.take && sts.classify) begin
          step_nxt  = '0;
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        if (sts.leaf) begin
          cmd.grade = 1'b1;
          fault_nxt = 1'b0;
          state_nxt = S_FIN;
        end else if (step_r == STEP_W'(MAX_DEPTH)) begin
          fault_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.feat_rd = 1'b1;
          state_nxt   = S_FEAT;
        end
      end
      S_FEAT: begin
        cmd.step  = 1'b1;
        step_nxt  = step_r + 1'b1;
        state_nxt = S_NODE;
      end
      S_FIN: begin
        cmd.fault = fault_r;
        if (!sts.out_hold) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      fault_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      fault_r <= fault_nxt;
    end
  end

endmodule

/* rtl/dtce_dp.sv */
// Datapath for the decision tree classifier: node, weight and feature
// memories, threshold compare, error accumulator and output register.
// Depends on dtce_pkg.
module dtce_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     in_tuser,
  input  logic [dtce_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dtce_pkg::OUT_DATA_W-1:0] out_tdata,
  input  dtce_pkg::dp_cmd_t              cmd,
  output dtce_pkg::dp_sts_t              sts
);
  import dtce_pkg::*;

  node_t    node_mem [NODES];
  weights_t wgt_mem  [NODES];
  logic signed [15:0] feat_mem [FEATURES];

  in_item_t           item;
  opcode_t            op;
  node_t              node_q;
  weights_t           wgt_q;
  logic signed [15:0] feat_q;
  logic [NODE_AW-1:0] node_raddr;
  logic               node_re;
  logic               go_left;
  logic               label_r;
  logic [23:0]        ew_r;
  logic               pred_r;
  logic               mis;
  logic [32:0]        sum;
  logic [31:0]        err_r, err_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               load;

  assign item    = in_item_t'(in_tdata);
  assign op      = opcode_t'(in_tuser);
  assign go_left = feat_q <= node_q.thresh;

  assign node_re    = (cmd.take && op == OP_CLASSIFY) || cmd.step;
  assign node_raddr = cmd.step ? (go_left ? node_q.left : node_q.right) : '0;

  always_ff @(posedge clk) begin
    if (cmd.take && op == OP_WRITE_NODE) begin
      node_mem[item.address[NODE_AW-1:0]] <= '{thresh: item.value,
                                                leaf:   item.is_leaf,
                                                feat:   item.feat_sel,
                                                left:   item.child_le,
                                                right:  item.child_gt};
      wgt_mem[item.address[NODE_AW-1:0]]  <= '{pos: item.pos_wt,
                                                neg: item.neg_wt};
    end
    if (cmd.take && op == OP_WRITE_FEAT && item.address < 8'(FEATURES)) begin
      feat_mem[item.address[FEAT_AW-1:0]] <= item.value;
    end
    if (node_re) begin
      node_q <= node_mem[node_raddr];
      wgt_q  <= wgt_mem[node_raddr];
    end
    if (cmd.feat_rd) begin
      feat_q <= feat_mem[node_q.feat[FEAT_AW-1:0]];
    end
    if (cmd.take) begin
      label_r <= item.true_label;
      ew_r    <= item.example_weight;
    end
    if (cmd.grade) begin
      pred_r <= wgt_q.pos < wgt_q.neg;
    end
  end

  assign mis  = (pred_r != label_r) && !cmd.fault;
  assign sum  = {1'b0, err_r} + {9'd0, ew_r};
  assign load = (cmd.take && op != OP_CLASSIFY) || cmd.finish;

  always_comb begin
    err_nxt = err_r;
    out_nxt = out_r;
    if (cmd.take && op == OP_CLEAR) begin
      err_nxt = '0;
    end else if (cmd.finish && mis) begin
      err_nxt = sum[32] ? '1 : sum[31:0];
    end
    if (load) begin
      out_nxt.pad                = '0;
      out_nxt.weighted_error     = err_nxt;
      out_nxt.walk_fault         = cmd.finish && cmd.fault;
      out_nxt.predicted_negative = cmd.finish && !cmd.fault && pred_r;
      out_nxt.mismatch           = cmd.finish && mis;
    end
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_r;
  assign sts.classify = op == OP_CLASSIFY;
  assign sts.leaf     = node_q.leaf;
  assign sts.out_hold = out_valid_r && !out_tready;

endmodule

/* rtl/decision_tree_classify_error.sv */
// Decision tree classifier with a saturating weighted error accumulator.
// Node, weight and feature writes and error clears finish on acceptance. A
// classify transaction walks the tree from node 0; each level is a node
// memory read followed by a feature memory read, down to the depth limit of
// 16 inner nodes. One transaction is in flight at a time; a new transaction
// is accepted only while the output register is empty or is being read in
// the same cycle, so a result held by the receiver stalls the input. Memory
// contents are undefined until written; the error total resets to zero.
// Depends on dtce_pkg, dtce_ctrl and dtce_dp.
module decision_tree_classify_error (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode
  input  logic [1:0]                      in_tuser,
  // address, value, is_leaf, feat_sel, child_le, child_gt,
  // pos_wt, neg_wt, true_label, example_weight
  input  logic [dtce_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // predicted_negative, mismatch, weighted_error, walk_fault, zero pad
  output logic [dtce_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dtce_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dtce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtce_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

/* tb/decision_tree_classify_error_tb.sv */
// Self-checking testbench for decision_tree_classify_error: loads trees and features,
// classifies examples and checks every result against a cycle-free tree walker.
// Depends on dtce_pkg and the decision_tree_classify_error RTL.
module decision_tree_classify_error_tb;
  import dtce_pkg::*;

  localparam int TARGET_ITEMS     = 1850;
  localparam int CALM_AFTER       = 1600;
  localparam int LONG_HOLD_AT     = 400;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int SAT_RUN_AT       = 900;
  localparam int SAT_RUN_LEN      = 270;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 1000000;

  class error_tally_board;
    node_t              nodes[NODES];
    weights_t           leaf_wts[NODES];
    bit                 node_known[NODES];
    logic signed [15:0] feats[FEATURES];
    bit                 feat_known[FEATURES];
    bit [31:0]          err_total;
    out_item_t          expected_q[$];
    int                 fails;
    int                 n_class;
    int                 n_fault;
    int                 n_mis;
    int                 n_sat;
    int                 deepest;

    task report(string msg);
      fails++;
      if (fails <= 40) $display("MISMATCH: %s", msg);
    endtask

    // walk from node 0; returns 0 and the first unwritten entry on the path, if any
    function bit trace(output int stop, output int depth, output int gap_node,
                       output int gap_feat);
      int    cur;
      node_t nd;
      cur = 0;
      depth = 0;
      stop = 0;
      gap_node = -1;
      gap_feat = -1;
      if (!node_known[0]) begin
        gap_node = 0;
        return 0;
      end
      nd = nodes[0];
      while (!nd.leaf && depth < MAX_DEPTH) begin
        if (!feat_known[nd.feat]) begin
          gap_feat = int'(nd.feat);
          return 0;
        end
        cur = ($signed(feats[nd.feat]) <= $signed(nd.thresh)) ? int'(nd.left) : int'(nd.right);
        if (!node_known[cur]) begin
          gap_node = cur;
          return 0;
        end
        nd = nodes[cur];
        depth++;
      end
      stop = cur;
      return 1;
    endfunction

    function void note_input(opcode_t op, in_item_t it);
      out_item_t exp_item;
      int        stop;
      int        depth;
      int        gn;
      int        gf;
      bit [32:0] sum;
      exp_item = '0;
      case (op)
        OP_WRITE_NODE: begin
          nodes[it.address] = '{thresh: it.value, leaf: it.is_leaf, feat: it.feat_sel,
                                left: it.child_le, right: it.child_gt};
          leaf_wts[it.address] = '{pos: it.pos_wt, neg: it.neg_wt};
          node_known[it.address] = 1'b1;
        end
        OP_WRITE_FEAT: begin
          if (it.address < FEATURES) begin
            feats[it.address[FEAT_AW-1:0]] = it.value;
            feat_known[it.address[FEAT_AW-1:0]] = 1'b1;
          end
        end
        OP_CLASSIFY: begin
          n_class++;
          void'(trace(stop, depth, gn, gf));
          if (depth > deepest) deepest = depth;
          if (!nodes[stop].leaf) begin
            exp_item.walk_fault = 1'b1;
            n_fault++;
          end else begin
            exp_item.predicted_negative = leaf_wts[stop].pos < leaf_wts[stop].neg;
            exp_item.mismatch = exp_item.predicted_negative != it.true_label;
            if (exp_item.mismatch) begin
              n_mis++;
              sum = {1'b0, err_total} + {9'd0, it.example_weight};
              if (sum[32]) begin
                err_total = '1;
                n_sat++;
              end else begin
                err_total = sum[31:0];
              end
            end
          end
        end
        OP_CLEAR: begin
          err_total = '0;
        end
        default: ;
      endcase
      exp_item.weighted_error = err_total;
      expected_q.push_front(exp_item);
    endfunction

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_q.pop_back();
      if (got.predicted_negative !== want.predicted_negative)
        report($sformatf("predicted_negative %b, want %b", got.predicted_negative,
                         want.predicted_negative));
      if (got.mismatch !== want.mismatch)
        report($sformatf("mismatch %b, want %b", got.mismatch, want.mismatch));
      if (got.weighted_error !== want.weighted_error)
        report($sformatf("weighted_error %h, want %h", got.weighted_error,
                         want.weighted_error));
      if (got.walk_fault !== want.walk_fault)
        report($sformatf("walk_fault %b, want %b", got.walk_fault, want.walk_fault));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [1:0]            in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  error_tally_board board;
  int               sent = 0;
  bit               calm = 1'b0;
  int               cycle_count = 0;

  decision_tree_classify_error uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic in_item_t rand_item();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[IN_DATA_W-1:0];
  endfunction

  function automatic logic [15:0] rand_q88();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] rand_w24();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 24'hFFFFFF;
      4: return 24'h000000;
      5: return 24'h000001;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_child();
    return ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 23)) : 8'($urandom());
  endfunction

  function automatic in_item_t make_node(int addr, bit force_leaf);
    in_item_t it;
    it = rand_item();
    it.address = 8'(addr);
    it.is_leaf = force_leaf || ($urandom_range(0, 2) == 0);
    it.feat_sel = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom());
    it.child_le = pick_child();
    it.child_gt = pick_child();
    it.value = rand_q88();
    if (board.feat_known[it.feat_sel] && $urandom_range(0, 3) == 0)
      it.value = board.feats[it.feat_sel];
    it.pos_wt = rand_w24();
    it.neg_wt = ($urandom_range(0, 4) == 0) ? it.pos_wt : rand_w24();
    return it;
  endfunction

  task automatic send_item(opcode_t op, in_item_t it);
    int gap;
    in_tuser <= op;
    in_tdata <= it;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_input(op, it);
    if (!(op == OP_WRITE_FEAT && it.address >= FEATURES)) sent++;
    gap = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_node(input logic [7:0] addr, input logic leaf, input logic [5:0] feat,
                          input logic [15:0] thresh, input logic [7:0] lc,
                          input logic [7:0] rc, input logic [23:0] pw,
                          input logic [23:0] nw);
    in_item_t it;
    it = rand_item();
    it.address = addr;
    it.is_leaf = leaf;
    it.feat_sel = feat;
    it.value = thresh;
    it.child_le = lc;
    it.child_gt = rc;
    it.pos_wt = pw;
    it.neg_wt = nw;
    send_item(OP_WRITE_NODE, it);
  endtask

  task automatic put_feat(input logic [7:0] addr, input logic [15:0] val);
    in_item_t it;
    it = rand_item();
    it.address = addr;
    it.value = val;
    send_item(OP_WRITE_FEAT, it);
  endtask

  task automatic put_classify(input logic label, input logic [23:0] weight);
    in_item_t it;
    it = rand_item();
    it.true_label = label;
    it.example_weight = weight;
    send_item(OP_CLASSIFY, it);
  endtask

  // fill unwritten nodes and features on the path first, then classify
  task automatic issue_classify(bit force_mis, bit max_weight);
    int       stop;
    int       depth;
    int       gn;
    int       gf;
    int       fills;
    bit       pred;
    in_item_t it;
    fills = 0;
    while (!board.trace(stop, depth, gn, gf)) begin
      if (gn >= 0) begin
        send_item(OP_WRITE_NODE, make_node(gn, fills >= 6));
      end else begin
        put_feat(8'(gf), rand_q88());
      end
      fills++;
    end
    pred = board.nodes[stop].leaf && (board.leaf_wts[stop].pos < board.leaf_wts[stop].neg);
    it = rand_item();
    it.true_label = (force_mis || $urandom_range(0, 3) != 0) ? !pred : pred;
    it.example_weight = max_weight ? 24'hFFFFFF : rand_w24();
    send_item(OP_CLASSIFY, it);
  endtask

  task automatic mix_item();
    in_item_t it;
    int       r;
    int       addr;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      case ($urandom_range(0, 9))
        0: addr = 0;
        1, 2, 3: addr = $urandom_range(0, 255);
        default: addr = $urandom_range(0, 23);
      endcase
      send_item(OP_WRITE_NODE, make_node(addr, 1'b0));
    end else if (r < 32) begin
      it = rand_item();
      it.value = rand_q88();
      it.address = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(FEATURES, 255))
                                               : 8'($urandom_range(0, FEATURES - 1));
      send_item(OP_WRITE_FEAT, it);
    end else if (r < 99) begin
      issue_classify(1'b0, 1'b0);
    end else begin
      send_item(OP_CLEAR, rand_item());
    end
  endtask

  // straight chain from node 0: len inner nodes that always go left, then a leaf
  task automatic chain_walk(int len);
    int       base;
    int       i;
    in_item_t it;
    base = $urandom_range(0, 255 - len);
    for (i = 0; i <= len; i++) begin
      it = make_node((i == 0) ? 0 : base + i, i == len);
      if (i < len) begin
        it.is_leaf = 1'b0;
        it.value = 16'sh7FFF;
        it.child_le = 8'(base + i + 1);
      end
      send_item(OP_WRITE_NODE, it);
    end
    repeat ($urandom_range(2, 5)) issue_classify(1'b0, 1'b0);
  endtask

  task automatic saturate_run();
    send_item(OP_CLEAR, rand_item());
    send_item(OP_WRITE_NODE, make_node(0, 1'b1));
    repeat (SAT_RUN_LEN) issue_classify(1'b1, 1'b1);
  endtask

  task automatic directed_items();
    send_item(OP_CLEAR, rand_item());
    put_feat(8'd0, 16'h8000);
    put_feat(8'd63, 16'h7FFF);
    put_feat(8'd64, 16'h1234);
    put_feat(8'd255, 16'hFFFF);
    put_node(8'd0, 1'b1, 6'd0, 16'h0000, 8'd0, 8'd0, 24'hFFFFFF, 24'hFFFFFF);
    put_classify(1'b0, 24'hFFFFFF);
    put_classify(1'b1, 24'hFFFFFF);
    put_node(8'd0, 1'b0, 6'd0, 16'h8000, 8'd1, 8'd2, 24'h0, 24'h0);
    put_node(8'd1, 1'b1, 6'd0, 16'h0000, 8'd0, 8'd0, 24'h000000, 24'h000001);
    put_node(8'd2, 1'b1, 6'd63, 16'h7FFF, 8'd255, 8'd255, 24'h000001, 24'h000000);
    put_classify(1'b0, 24'h000000);
    put_node(8'd0, 1'b0, 6'd63, 16'h7FFE, 8'd1, 8'd2, 24'h0, 24'h0);
    put_classify(1'b1, 24'hFFFFFF);
    put_feat(8'd63, 16'h7FFE);
    put_classify(1'b1, 24'h123456);
    put_node(8'd255, 1'b1, 6'd63, 16'h8000, 8'd255, 8'd255, 24'hFFFFFF, 24'h0);
    put_node(8'd0, 1'b0, 6'd0, 16'h0000, 8'd0, 8'd0, 24'h0, 24'h0);
    put_classify(1'b0, 24'hFFFFFF);
    send_item(OP_CLEAR, rand_item());
    put_classify(1'b1, 24'hFFFFFF);
  endtask

  initial begin
    bit sat_done;
    int len;
    sat_done = 1'b0;
    board = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= OP_CLEAR;
    in_tdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    while (sent < TARGET_ITEMS) begin
      if (!sat_done && sent >= SAT_RUN_AT) begin
        saturate_run();
        sat_done = 1'b1;
      end else if ($urandom_range(0, 79) == 0) begin
        case ($urandom_range(0, 5))
          0: len = 16;
          1: len = 17;
          2: len = 15;
          default: len = $urandom_range(2, 20);
        endcase
        chain_walk(len);
      end else begin
        mix_item();
      end
      if (sent >= CALM_AFTER) calm = 1'b1;
    end
    in_tvalid <= 1'b0;
    while (board.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Classified %0d examples: %0d walk faults, %0d label mismatches,",
             board.n_class, board.n_fault, board.n_mis);
    $display("%0d saturating adds, deepest walk %0d levels, %0d transactions, %0d-cycle hold-off.",
             board.n_sat, board.deepest, sent, LONG_HOLD_CYCLES);
    if (board.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int stall;
    bit hold_done;
    stall = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) board.check_result(out_item_t'(out_tdata));
      if (!hold_done && sent >= LONG_HOLD_AT) begin
        hold_done = 1'b1;
        stall = LONG_HOLD_CYCLES;
      end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19);
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

endmodule
